[rtl/core/gbc_pkg.sv]
`timescale 1ns / 1ps

package gbc_pkg;

    // Samples per warm-up tick
    localparam int TEMP_DIVIDE = 10;

    localparam int GYRO_W   = 24;
    localparam int BIAS_W   = 36;
    localparam int CFG_W    = 36;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(BIAS_W);

    localparam logic [CFG_IDX_W-1:0] CFG_STILL_GYRO_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SQ_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SQ_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_COUNT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LPF_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_TRIM          = 3'd7;

    typedef enum logic [1:0] {
        PHASE_WARMUP = 2'd0,
        PHASE_CALIB  = 2'd1,
        PHASE_RUN    = 2'd2
    } phase_t;

    typedef struct packed {
        logic signed [GYRO_W-1:0] gyro_x;
        logic signed [GYRO_W-1:0] gyro_y;
        logic signed [GYRO_W-1:0] gyro_z;
        logic signed [GYRO_W-1:0] accel_x;
        logic signed [GYRO_W-1:0] accel_y;
        logic signed [GYRO_W-1:0] accel_z;
        logic                     recal_button;
        logic                     switch_zero;
    } sample_t;

    typedef struct packed {
        logic signed [GYRO_W-1:0] rate_x;
        logic signed [GYRO_W-1:0] rate_y;
        logic signed [GYRO_W-1:0] rate_z;
        logic [1:0]               phase;
        logic                     rates_valid;
        logic                     at_rest;
    } result_t;

endpackage

[rtl/core/gbc_divider.sv]
`timescale 1ns / 1ps

// Signed dividend by unsigned divisor, quotient truncated toward zero.
// Restoring division, one quotient bit per cycle.
module gbc_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [gbc_pkg::BIAS_W-1:0]  dividend,
    input  logic [12:0]                        divisor,
    output logic                               done,
    output logic signed [gbc_pkg::BIAS_W-1:0]  quotient
);
    import gbc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic [BIAS_W-1:0]     work_reg;
    logic [12:0]           rem_reg;
    logic [12:0]           divisor_reg;
    logic [BIAS_W-1:0]     quot_reg;

    logic [BIAS_W-1:0]     mag;
    logic [13:0]           shifted;
    logic                  qbit;
    logic [12:0]           rem_next;
    logic [BIAS_W-1:0]     q_final;

    assign mag     = dividend[BIAS_W-1] ? (~dividend + 1'b1) : dividend;
    assign shifted = {rem_reg, work_reg[BIAS_W-1]};
    assign qbit    = (shifted >= {1'b0, divisor_reg});
    assign rem_next = qbit ? 13'(shifted - {1'b0, divisor_reg}) : shifted[12:0];
    assign q_final = {work_reg[BIAS_W-2:0], qbit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_W'(BIAS_W - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg     <= dividend[BIAS_W-1];
            work_reg    <= mag;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= q_final;
            rem_reg  <= rem_next;
            if (count_reg == '0)
                quot_reg <= neg_reg ? (~q_final + 1'b1) : q_final;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[rtl/core/gyro_bias_calibrator.sv]
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_ready  gbc_pkg::sample_t
// result    out        result_valid / result_ready  gbc_pkg::result_t
// cfg       in         cfg_we (no wait)             cfg_index, cfg_data
//
// The last calibrating item divides each axis sum in turn on the serial
// divider; the single shared 36x25 multiplier forms the accel squares and
// the bias low-pass of running items. Reset is asynchronous, active low;
// control state and config registers come up at defaults. A finished
// result waits in the output register; the next sample is taken meanwhile
// and stalls only at its own result write.
`timescale 1ns / 1ps

module gyro_bias_calibrator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  gbc_pkg::sample_t                  sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output gbc_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbc_pkg::CFG_W-1:0]         cfg_data
);
    import gbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CALIB,
        S_DIV_START,
        S_DIV_WAIT,
        S_SQUARE,
        S_REST,
        S_LOWPASS,
        S_RATES,
        S_FINISH
    } state_t;

    // Configuration
    logic [22:0]        still_gyro_limit_reg;
    logic [35:0]        accel_sq_low_reg;
    logic [35:0]        accel_sq_high_reg;
    logic [9:0]         rest_limit_reg;
    logic [16:0]        bias_lpf_gain_reg;
    logic [9:0]         warmup_ticks_reg;
    logic [12:0]        calib_samples_reg;
    logic signed [23:0] yaw_trim_reg;

    // Control and state
    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic               button_last_reg, button_last_next;
    logic [3:0]         decimate_reg, decimate_next;
    logic [10:0]        warmup_reg, warmup_next;
    logic [12:0]        calib_reg, calib_next;
    logic [9:0]         rest_count_reg, rest_count_next;
    logic signed [BIAS_W-1:0] bias_reg [3];
    logic signed [BIAS_W-1:0] bias_next [3];
    logic [1:0]         step_reg, step_next;
    logic [1:0]         axis_reg, axis_next;
    logic               run_reg, run_next;
    logic               at_rest_reg, at_rest_next;
    logic               result_valid_reg, result_valid_next;

    // Datapath
    sample_t            sample_reg, sample_next;
    logic signed [52:0] prod_reg;
    logic signed [52:0] acc_reg, acc_next;
    logic signed [37:0] diff_reg [3];
    logic signed [37:0] diff_next [3];
    result_t            result_reg, result_next;

    logic signed [GYRO_W-1:0] gyro_arr [3];
    logic signed [GYRO_W-1:0] accel_arr [3];

    logic signed [BIAS_W-1:0] mul_a;
    logic signed [24:0]       mul_b;
    logic signed [60:0]       mul_p;

    logic                     div_start;
    logic                     div_done;
    logic signed [BIAS_W-1:0] div_quot;
    logic [12:0]              div_eff;

    logic [16:0]        lpf_k;
    logic [16:0]        lpf_w;
    logic               gyro_ok;
    logic [23:0]        gyro_mag [3];

    function automatic logic signed [BIAS_W-1:0] sat36(input logic signed [BIAS_W:0] s);
        logic signed [BIAS_W-1:0] r;
        if (s[BIAS_W] != s[BIAS_W-1])
            r = s[BIAS_W] ? {1'b1, {(BIAS_W-1){1'b0}}} : {1'b0, {(BIAS_W-1){1'b1}}};
        else
            r = s[BIAS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [GYRO_W-1:0] sat24(input logic signed [37:0] d);
        logic signed [GYRO_W-1:0] r;
        if (d > 38'sd8388607)
            r = 24'sh7FFFFF;
        else if (d < -38'sd8388608)
            r = 24'sh800000;
        else
            r = d[GYRO_W-1:0];
        return r;
    endfunction

    assign gyro_arr[0]  = sample_reg.gyro_x;
    assign gyro_arr[1]  = sample_reg.gyro_y;
    assign gyro_arr[2]  = sample_reg.gyro_z;
    assign accel_arr[0] = sample_reg.accel_x;
    assign accel_arr[1] = sample_reg.accel_y;
    assign accel_arr[2] = sample_reg.accel_z;

    assign lpf_k   = bias_lpf_gain_reg[16] ? 17'h10000 : bias_lpf_gain_reg;
    assign lpf_w   = 17'h10000 - lpf_k;
    assign div_eff = (calib_samples_reg == '0) ? 13'd1 : calib_samples_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            gyro_mag[i] = gyro_arr[i][GYRO_W-1] ? (~gyro_arr[i] + 1'b1) : gyro_arr[i];
    end

    assign gyro_ok = (gyro_mag[0] < {1'b0, still_gyro_limit_reg}) &&
                     (gyro_mag[1] < {1'b0, still_gyro_limit_reg}) &&
                     (gyro_mag[2] < {1'b0, still_gyro_limit_reg});

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQUARE && step_reg != 2'd3)
        begin
            mul_a = {{12{accel_arr[step_reg][23]}}, accel_arr[step_reg]};
            mul_b = {accel_arr[step_reg][23], accel_arr[step_reg]};
        end
        else if (state_reg == S_LOWPASS && step_reg == 2'd0)
        begin
            mul_a = bias_reg[axis_reg];
            mul_b = {8'd0, lpf_w};
        end
        else if (state_reg == S_LOWPASS && step_reg == 2'd1)
        begin
            mul_a = {{12{gyro_arr[axis_reg][23]}}, gyro_arr[axis_reg]};
            mul_b = {8'd0, lpf_k};
        end
    end

    assign mul_p = mul_a * mul_b;

    assign div_start = (state_reg == S_DIV_START);

    gbc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (bias_reg[axis_reg]),
        .divisor  (div_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        logic               restart;
        phase_t             phase_eff;
        logic [10:0]        warm_eff;
        logic [10:0]        warm_inc;
        logic [4:0]         dec_inc;
        logic [12:0]        calib_inc;
        logic               rest;
        logic signed [52:0] lp_sum;

        state_next        = state_reg;
        phase_next        = phase_reg;
        button_last_next  = button_last_reg;
        decimate_next     = decimate_reg;
        warmup_next       = warmup_reg;
        calib_next        = calib_reg;
        rest_count_next   = rest_count_reg;
        bias_next         = bias_reg;
        step_next         = step_reg;
        axis_next         = axis_reg;
        run_next          = run_reg;
        at_rest_next      = at_rest_reg;
        sample_next       = sample_reg;
        acc_next          = acc_reg;
        diff_next         = diff_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg & ~result_ready;

        restart   = sample_reg.recal_button & ~button_last_reg & sample_reg.switch_zero;
        phase_eff = restart ? PHASE_WARMUP : phase_reg;
        warm_eff  = restart ? 11'd0 : warmup_reg;
        warm_inc  = (warm_eff == 11'h7FF) ? warm_eff : warm_eff + 11'd1;
        dec_inc   = {1'b0, decimate_reg} + 5'd1;
        calib_inc = (calib_reg == 13'h1FFF) ? calib_reg : calib_reg + 13'd1;
        rest      = gyro_ok && (acc_reg[47:0] > {12'd0, accel_sq_low_reg}) &&
                    (acc_reg[47:0] < {12'd0, accel_sq_high_reg});
        lp_sum    = acc_reg + prod_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next = sample;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                button_last_next = sample_reg.recal_button;
                decimate_next = (dec_inc >= 5'(TEMP_DIVIDE)) ? 4'd0 : dec_inc[3:0];
                run_next     = 1'b0;
                at_rest_next = 1'b0;
                if (restart)
                begin
                    phase_next      = PHASE_WARMUP;
                    warmup_next     = '0;
                    calib_next      = '0;
                    rest_count_next = '0;
                    for (int i = 0; i < 3; i++)
                        bias_next[i] = '0;
                end
                unique case (phase_eff)
                    PHASE_RUN:
                    begin
                        run_next   = 1'b1;
                        step_next  = 2'd0;
                        state_next = S_SQUARE;
                    end
                    PHASE_CALIB:
                        state_next = S_CALIB;
                    default:
                    begin
                        // Warm-up tick on the first sample of each decimation group
                        if (decimate_reg == '0)
                        begin
                            warmup_next = warm_inc;
                            if (warm_inc > {1'b0, warmup_ticks_reg})
                                phase_next = PHASE_CALIB;
                        end
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_CALIB:
            begin
                for (int i = 0; i < 3; i++)
                    bias_next[i] = sat36({bias_reg[i][BIAS_W-1], bias_reg[i]} +
                                         {{13{gyro_arr[i][23]}}, gyro_arr[i]});
                calib_next = calib_inc;
                if (calib_inc >= div_eff)
                begin
                    axis_next  = 2'd0;
                    state_next = S_DIV_START;
                end
                else
                    state_next = S_FINISH;
            end
            S_DIV_START:
                state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    bias_next[axis_reg] = div_quot;
                    if (axis_reg == 2'd2)
                    begin
                        phase_next = PHASE_RUN;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_SQUARE:
            begin
                // Squared accel norm: one product per cycle, summed in the cycle after
                if (step_reg == 2'd1)
                    acc_next = prod_reg;
                else if (step_reg != 2'd0)
                    acc_next = acc_reg + prod_reg;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = S_REST;
            end
            S_REST:
            begin
                at_rest_next = rest;
                if (!rest)
                begin
                    rest_count_next = '0;
                    state_next      = S_RATES;
                end
                else if (rest_count_reg < rest_limit_reg)
                begin
                    rest_count_next = rest_count_reg + 10'd1;
                    state_next      = S_RATES;
                end
                else
                begin
                    axis_next  = 2'd0;
                    step_next  = 2'd0;
                    state_next = S_LOWPASS;
                end
            end
            S_LOWPASS:
            begin
                unique case (step_reg)
                    2'd0:
                    begin
                        acc_next  = 53'sd32768;
                        step_next = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next  = acc_reg + prod_reg;
                        step_next = 2'd2;
                    end
                    default:
                    begin
                        // Arithmetic shift gives the floor
                        bias_next[axis_reg] = lp_sum[51:16];
                        step_next = 2'd0;
                        if (axis_reg == 2'd2)
                            state_next = S_RATES;
                        else
                            axis_next = axis_reg + 2'd1;
                    end
                endcase
            end
            S_RATES:
            begin
                for (int i = 0; i < 3; i++)
                    diff_next[i] = {{14{gyro_arr[i][23]}}, gyro_arr[i]} -
                                   {{2{bias_reg[i][BIAS_W-1]}}, bias_reg[i]};
                diff_next[2] = diff_next[2] - {{14{yaw_trim_reg[23]}}, yaw_trim_reg};
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    result_next.rate_x      = run_reg ? sat24(diff_reg[0]) : '0;
                    result_next.rate_y      = run_reg ? sat24(diff_reg[1]) : '0;
                    result_next.rate_z      = run_reg ? sat24(diff_reg[2]) : '0;
                    result_next.phase       = phase_reg;
                    result_next.rates_valid = run_reg;
                    result_next.at_rest     = at_rest_reg;
                    result_valid_next       = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PHASE_WARMUP;
            button_last_reg  <= 1'b0;
            decimate_reg     <= '0;
            warmup_reg       <= '0;
            calib_reg        <= '0;
            rest_count_reg   <= '0;
            for (int i = 0; i < 3; i++)
                bias_reg[i] <= '0;
            step_reg         <= '0;
            axis_reg         <= '0;
            run_reg          <= 1'b0;
            at_rest_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            button_last_reg  <= button_last_next;
            decimate_reg     <= decimate_next;
            warmup_reg       <= warmup_next;
            calib_reg        <= calib_next;
            rest_count_reg   <= rest_count_next;
            bias_reg         <= bias_next;
            step_reg         <= step_next;
            axis_reg         <= axis_next;
            run_reg          <= run_next;
            at_rest_reg      <= at_rest_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        prod_reg   <= mul_p[52:0];
        acc_reg    <= acc_next;
        diff_reg   <= diff_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_gyro_limit_reg  <= 23'd1311;
            accel_sq_low_reg      <= 36'd3635260339;
            accel_sq_high_reg     <= 36'd5009649854;
            rest_limit_reg        <= 10'd200;
            bias_lpf_gain_reg     <= 17'd655;
            warmup_ticks_reg      <= 10'd300;
            calib_samples_reg     <= 13'd1000;
            yaw_trim_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STILL_GYRO_LIMIT:  still_gyro_limit_reg  <= cfg_data[22:0];
                CFG_ACCEL_SQ_LOW:      accel_sq_low_reg      <= cfg_data[35:0];
                CFG_ACCEL_SQ_HIGH:     accel_sq_high_reg     <= cfg_data[35:0];
                CFG_REST_COUNT_LIMIT:  rest_limit_reg        <= cfg_data[9:0];
                CFG_BIAS_LPF_GAIN:     bias_lpf_gain_reg     <= cfg_data[16:0];
                CFG_WARMUP_TICKS:      warmup_ticks_reg      <= cfg_data[9:0];
                CFG_CALIB_SAMPLES:     calib_samples_reg     <= cfg_data[12:0];
                CFG_YAW_TRIM:          yaw_trim_reg          <= cfg_data[23:0];
            endcase
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[sim/tb_gyro_bias_calibrator.sv]
`timescale 1ns / 1ps

module tb_gyro_bias_calibrator;

    import gbc_pkg::*;

    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     SETTLE_CYCLES = 150;
    localparam int     RANDOM_ITEMS  = 1700;
    localparam int     G_MAX         = 8388607;
    localparam int     G_MIN         = -8388608;
    localparam int     ONE_G         = 65536;
    localparam longint SUM_MAX       = 64'sd34359738367;
    localparam longint SUM_MIN       = -64'sd34359738368;
    localparam longint NORM_LO_RST   = 64'sd3635260339;
    localparam longint NORM_HI_RST   = 64'sd5009649854;
    localparam longint NORM_MAX      = 64'sd68719476735;
    localparam longint ONE_G_SQ      = 64'sd4294967296;

    typedef enum {KIND_REST, KIND_MOVING, KIND_NOISE} sample_kind_t;

    class bias_scoreboard;
        longint  rest_rate_lim = 1311;
        longint  norm_lo       = NORM_LO_RST;
        longint  norm_hi       = NORM_HI_RST;
        longint  rest_needed   = 200;
        longint  lpf_k         = 655;
        longint  warm_len      = 300;
        longint  calib_len     = 1000;
        longint  z_trim        = 0;

        phase_t  cur_phase     = PHASE_WARMUP;
        bit      prev_button   = 1'b0;
        int      div_count     = 0;
        int      tick_count    = 0;
        int      sum_count     = 0;
        int      rest_run      = 0;
        longint  bias[3]       = '{0, 0, 0};

        result_t expected_rates[$];
        int      errors, n_samples, n_results, n_running, n_rest, n_restarts, n_writes;

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            n_writes++;
            case (idx)
                CFG_STILL_GYRO_LIMIT:  rest_rate_lim = d[22:0];
                CFG_ACCEL_SQ_LOW:      norm_lo = d;
                CFG_ACCEL_SQ_HIGH:     norm_hi = d;
                CFG_REST_COUNT_LIMIT:  rest_needed = d[9:0];
                CFG_BIAS_LPF_GAIN:     lpf_k = d[16:0];
                CFG_WARMUP_TICKS:      warm_len = d[9:0];
                CFG_CALIB_SAMPLES:     calib_len = d[12:0];
                CFG_YAW_TRIM:          z_trim = $signed(d[23:0]);
                default: ;
            endcase
        endfunction

        // Advance the calibrator state by one sample and queue the rates it yields.
        function void add_sample(sample_t s);
            longint  g[3];
            longint  acc[3];
            longint  r[3];
            longint  norm, mag, k, t, dv;
            bit      calm, rest, run;
            result_t e;
            g[0] = $signed(s.gyro_x);
            g[1] = $signed(s.gyro_y);
            g[2] = $signed(s.gyro_z);
            acc[0] = $signed(s.accel_x);
            acc[1] = $signed(s.accel_y);
            acc[2] = $signed(s.accel_z);
            foreach (r[i])
                r[i] = 0;
            rest = 1'b0;
            run = 1'b0;
            n_samples++;

            if (s.recal_button && !prev_button && s.switch_zero)
            begin
                cur_phase = PHASE_WARMUP;
                tick_count = 0;
                sum_count = 0;
                rest_run = 0;
                foreach (bias[i])
                    bias[i] = 0;
                n_restarts++;
            end
            prev_button = s.recal_button;

            if (cur_phase == PHASE_RUN)
            begin
                calm = 1'b1;
                norm = 0;
                for (int i = 0; i < 3; i++)
                begin
                    mag = g[i] < 0 ? -g[i] : g[i];
                    if (mag >= rest_rate_lim)
                        calm = 1'b0;
                    norm += acc[i] * acc[i];
                end
                rest = calm && norm > norm_lo && norm < norm_hi;
                if (!rest)
                    rest_run = 0;
                else if (rest_run < rest_needed)
                    rest_run++;
                else
                begin
                    k = lpf_k > 65536 ? 65536 : lpf_k;
                    for (int i = 0; i < 3; i++)
                    begin
                        t = bias[i] * (65536 - k) + g[i] * k + 32768;
                        bias[i] = t >>> 16;
                    end
                end
                r[0] = clip(g[0] - bias[0], G_MIN, G_MAX);
                r[1] = clip(g[1] - bias[1], G_MIN, G_MAX);
                r[2] = clip(g[2] - bias[2] - z_trim, G_MIN, G_MAX);
                run = 1'b1;
                n_running++;
                if (rest)
                    n_rest++;
            end
            else if (cur_phase == PHASE_CALIB)
            begin
                dv = calib_len == 0 ? 1 : calib_len;
                for (int i = 0; i < 3; i++)
                    bias[i] = clip(bias[i] + g[i], SUM_MIN, SUM_MAX);
                if (sum_count < 8191)
                    sum_count++;
                if (sum_count >= dv)
                begin
                    for (int i = 0; i < 3; i++)
                        bias[i] = bias[i] / dv;
                    cur_phase = PHASE_RUN;
                end
            end

            if (div_count == 0 && cur_phase == PHASE_WARMUP)
            begin
                if (tick_count < 2047)
                    tick_count++;
                if (tick_count > warm_len)
                    cur_phase = PHASE_CALIB;
            end
            div_count++;
            if (div_count >= TEMP_DIVIDE)
                div_count = 0;

            e.rate_x = r[0][23:0];
            e.rate_y = r[1][23:0];
            e.rate_z = r[2][23:0];
            e.phase = cur_phase;
            e.rates_valid = run;
            e.at_rest = rest;
            expected_rates.push_back(e);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_rates(result_t got);
            result_t want;
            if (expected_rates.size() == 0)
            begin
                $error("result transaction with no sample outstanding");
                errors++;
                return;
            end
            want = expected_rates.pop_front();
            n_results++;
            compare_field("rate_x", want.rate_x, got.rate_x);
            compare_field("rate_y", want.rate_y, got.rate_y);
            compare_field("rate_z", want.rate_z, got.rate_z);
            compare_field("phase", want.phase, got.phase);
            compare_field("rates_valid", want.rates_valid, got.rates_valid);
            compare_field("at_rest", want.at_rest, got.at_rest);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_ready;
    sample_t              sample;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bias_scoreboard scoreboard = new();

    int sample_gap_pct = 32;
    int ready_idle_pct = 32;
    int ready_hold     = 0;
    int cur_gyro_lim   = 1311;
    int stim_items     = 0;
    int n_phases       = 0;

    gyro_bias_calibrator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, scoreboard.expected_rates.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random back-pressure, plus long hold-offs on request.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                result_ready <= 1'b0;
                ready_hold = ready_hold - 1;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            scoreboard.check_rates(result);
    end

    function automatic int signed_rand(input int mag);
        int m;
        m = int'($urandom_range(0, mag));
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic sample_t mk(input int gx, gy, gz, ax, ay, az, input bit btn, sw);
        sample_t s;
        s.gyro_x = gx[23:0];
        s.gyro_y = gy[23:0];
        s.gyro_z = gz[23:0];
        s.accel_x = ax[23:0];
        s.accel_y = ay[23:0];
        s.accel_z = az[23:0];
        s.recal_button = btn;
        s.switch_zero = sw;
        return s;
    endfunction

    function automatic sample_t make_sample(input sample_kind_t kind, input int restart_permil);
        int gv[3];
        int av[3];
        int span;
        bit btn, sw;
        btn = ($urandom_range(0, 19) == 0);
        sw = btn ? 1'b0 : 1'($urandom_range(0, 1));
        case (kind)
            KIND_REST:
            begin
                span = cur_gyro_lim > 3001 ? 3000 : cur_gyro_lim - 1;
                foreach (gv[i])
                    gv[i] = span > 0 ? signed_rand(span) : 0;
                // Put one axis right on the rest limit now and then.
                if ($urandom_range(0, 15) == 0)
                    gv[$urandom_range(0, 2)] = $urandom_range(0, 1) ? cur_gyro_lim : -cur_gyro_lim;
                if ($urandom_range(0, 3) == 0)
                begin
                    av = '{0, 0, 0};
                    av[$urandom_range(0, 2)] = $urandom_range(0, 1) ? ONE_G : -ONE_G;
                end
                else
                begin
                    av[0] = signed_rand(3000);
                    av[1] = signed_rand(3000);
                    av[2] = ($urandom_range(0, 1) ? 1 : -1) * (ONE_G + signed_rand(3000));
                end
            end
            KIND_MOVING:
            begin
                foreach (gv[i])
                    gv[i] = signed_rand(300000);
                av[0] = signed_rand(40000);
                av[1] = signed_rand(40000);
                av[2] = ONE_G + signed_rand(40000);
            end
            default:
            begin
                foreach (gv[i])
                    gv[i] = int'($urandom);
                foreach (av[i])
                    av[i] = int'($urandom);
                btn = 1'($urandom_range(0, 1));
                sw = 1'($urandom_range(0, 1));
            end
        endcase
        if ($urandom_range(0, 999) < restart_permil)
        begin
            btn = 1'b1;
            sw = 1'b1;
        end
        return mk(gv[0], gv[1], gv[2], av[0], av[1], av[2], btn, sw);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input sample_t s);
        while ($urandom_range(0, 99) < sample_gap_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        scoreboard.add_sample(s);
        @(negedge clk);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (scoreboard.expected_rates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_W-1:0];
        scoreboard.set_reg(idx, v[CFG_W-1:0]);
        @(negedge clk);
    endtask

    task automatic program_regs(input longint lim, lo, hi, cnt, gain, warm, calib, trim);
        write_reg(CFG_STILL_GYRO_LIMIT, lim);
        write_reg(CFG_ACCEL_SQ_LOW, lo);
        write_reg(CFG_ACCEL_SQ_HIGH, hi);
        write_reg(CFG_REST_COUNT_LIMIT, cnt);
        write_reg(CFG_BIAS_LPF_GAIN, gain);
        write_reg(CFG_WARMUP_TICKS, warm);
        write_reg(CFG_CALIB_SAMPLES, calib);
        write_reg(CFG_YAW_TRIM, trim);
        cfg_we <= 1'b0;
        cur_gyro_lim = int'(lim);
        n_phases++;
    endtask

    task automatic run_phase(input int n_items, rest_pct, restart_permil, input bit restart_first);
        sample_t      s;
        sample_kind_t kind;
        int           pick;
        if (restart_first)
        begin
            s = make_sample(KIND_REST, 0);
            s.recal_button = 1'b0;
            send_sample(s);
            s.recal_button = 1'b1;
            s.switch_zero = 1'b1;
            send_sample(s);
        end
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < rest_pct)
                kind = KIND_REST;
            else if (pick < rest_pct + (100 - rest_pct) / 2)
                kind = KIND_MOVING;
            else
                kind = KIND_NOISE;
            send_sample(make_sample(kind, restart_permil));
            stim_items++;
        end
        drain();
    endtask

    initial
    begin
        sample_t directed_list[$];
        int      pick;

        sample_valid = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Quick path to running: one tick of warm-up, a one-sample average.
        program_regs(1311, NORM_LO_RST, NORM_HI_RST, 1, 65536, 0, 1, G_MIN);
        directed_list.push_back(mk(G_MAX, G_MIN, 0, G_MAX, G_MIN, G_MAX, 0, 0));
        directed_list.push_back(mk(G_MAX, G_MIN, 0, 0, 0, 0, 0, 0));
        directed_list.push_back(mk(G_MIN, G_MAX, G_MAX, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(0, 0, 0, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(1310, -1310, 0, 0, ONE_G, 0, 0, 0));
        directed_list.push_back(mk(1311, 0, 0, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(0, -1311, 0, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(0, 0, -1310, 0, 0, -ONE_G, 0, 0));
        directed_list.push_back(mk(-1, 0, 0, ONE_G, 0, 0, 0, 0));
        directed_list.push_back(mk(5, 5, 5, G_MAX, G_MAX, G_MAX, 0, 0));
        directed_list.push_back(mk(5, 5, 5, G_MIN, G_MIN, G_MIN, 0, 0));
        directed_list.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
        // Button edge with the switch off, then held, then a real restart.
        directed_list.push_back(mk(0, 0, 0, 0, 0, ONE_G, 1, 0));
        directed_list.push_back(mk(0, 0, 0, 0, 0, ONE_G, 1, 1));
        directed_list.push_back(mk(0, 0, 0, 0, 0, ONE_G, 0, 1));
        directed_list.push_back(mk(0, 0, 0, 0, 0, ONE_G, 1, 1));
        directed_list.push_back(mk(G_MIN, G_MIN, G_MIN, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(G_MAX, G_MAX, G_MAX, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(-7, 8, -9, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(1, 2, 3, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(100, -100, 50, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(G_MAX, G_MIN, G_MAX, 0, 0, ONE_G, 0, 0));
        directed_list.push_back(mk(0, 0, 0, 0, 0, ONE_G, 0, 0));
        foreach (directed_list[i])
            send_sample(directed_list[i]);
        drain();

        program_regs(2000, NORM_LO_RST, NORM_HI_RST, 5, 655, 2, 4, signed_rand(100000));
        run_phase(150, 70, 10, 1'b1);

        // No idling on either side for this stretch.
        sample_gap_pct = 0;
        ready_idle_pct = 0;
        program_regs(1311, NORM_LO_RST, NORM_HI_RST, 0, 65536, 0, 0, 0);
        run_phase(150, 80, 5, 1'b1);
        sample_gap_pct = 32;
        ready_idle_pct = 32;

        // Hold the result side off so the block backs up into its input.
        program_regs(G_MAX, 0, NORM_MAX, 3, 131071, 1, 3, G_MIN);
        ready_hold = 400;
        run_phase(150, 80, 5, 1'b1);

        program_regs(0, 0, ONE_G_SQ, 2, 40000, 1, 2, G_MAX);
        run_phase(80, 70, 5, 1'b1);

        program_regs(1500, ONE_G_SQ - 1, ONE_G_SQ + 1, 1, 0, 0, 5, signed_rand(G_MAX));
        run_phase(100, 85, 5, 1'b1);

        program_regs(2000, ONE_G_SQ, NORM_HI_RST, 1023, 30000, 0, 2, 0);
        run_phase(250, 95, 0, 1'b1);

        program_regs(1311, NORM_LO_RST, NORM_HI_RST, 200, 655, 1023, 1000, 0);
        run_phase(120, 70, 0, 1'b1);

        // Leave calibration unfinished; the next setting shortens it.
        program_regs(1311, NORM_LO_RST, NORM_HI_RST, 10, 655, 1, 4096, 0);
        run_phase(150, 70, 0, 1'b1);

        while (stim_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 3);
            program_regs($urandom_range(300, 20000),
                         pick == 0 ? 0 : NORM_LO_RST,
                         pick == 0 ? NORM_MAX : NORM_HI_RST,
                         $urandom_range(0, 30), $urandom_range(0, 131071),
                         $urandom_range(0, 3), $urandom_range(0, 30),
                         signed_rand(G_MAX));
            run_phase(120, 75, 8, 1'b0);
        end

        $display("Covered %0d samples over %0d register settings: %0d running, %0d at rest,",
                 scoreboard.n_samples, n_phases, scoreboard.n_running, scoreboard.n_rest);
        $display("%0d restarts; checked %0d results, %0d register writes, %0d mismatches",
                 scoreboard.n_restarts, scoreboard.n_results, scoreboard.n_writes,
                 scoreboard.errors);
        if (scoreboard.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
